### sv/dlvm_pkg.sv
`timescale 1ns / 1ps

package dlvm_pkg;

   // root unit: one result bit per pipeline stage
   localparam int STEPS  = 16;
   localparam int ROOT_W = STEPS + 1;
   localparam int DEN_W  = 32;
   localparam int NUM_W  = 62;
   localparam int PROD_W = 52;
   localparam int ACC_W  = 72;

   localparam int COMP_W  = 16;
   localparam int SQ_W    = 31;
   localparam int SUM_W   = 32;
   localparam int SHIFT_W = 17;
   localparam int FRAC_Q  = 14;
   localparam int NORM_SH = 30;

   typedef struct packed {
      logic degen;
      logic neg_x;
      logic neg_y;
      logic neg_z;
   } tag_type;

endpackage

### sv/dlvm_root.sv
`timescale 1ns / 1ps

// largest r with (2r-1)^2 * den <= num, one bit of r per stage
module dlvm_root (
   input  logic                         clock,
   input  logic                         en,
   input  logic [dlvm_pkg::DEN_W-1:0]   den_i,
   input  logic [dlvm_pkg::NUM_W-1:0]   num_i,
   output logic [dlvm_pkg::ROOT_W-1:0]  root_o
);

   logic [dlvm_pkg::ACC_W-1:0]  rem_ff  [0:dlvm_pkg::STEPS-1];
   logic [dlvm_pkg::PROD_W-1:0] prod_ff [0:dlvm_pkg::STEPS-1];
   logic [dlvm_pkg::DEN_W-1:0]  den_ff  [0:dlvm_pkg::STEPS-1];
   logic [dlvm_pkg::ROOT_W-1:0] root_ff [0:dlvm_pkg::STEPS];

   logic [dlvm_pkg::ACC_W-1:0]  num_ext;
   logic [dlvm_pkg::ACC_W-1:0]  den_ext;
   logic                        first_fit;

   // first stage tries r = 1
   assign num_ext   = dlvm_pkg::ACC_W'(num_i);
   assign den_ext   = dlvm_pkg::ACC_W'(den_i);
   assign first_fit = num_ext >= den_ext;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= first_fit ? num_ext - den_ext : num_ext;
         root_ff[0] <= first_fit ? dlvm_pkg::ROOT_W'(1) : '0;
         prod_ff[0] <= dlvm_pkg::PROD_W'(den_i);
         den_ff[0]  <= den_i;
      end
   end

   genvar k;
   for (k = 1; k <= dlvm_pkg::STEPS; k++) begin : g_step
      localparam int J = dlvm_pkg::STEPS - k;
      logic [dlvm_pkg::ACC_W-1:0] trial;
      logic                       fit;

      // y grows by 2^(J+1): y'^2 den - y^2 den = 2^(J+2) (den*y + den*2^J)
      assign trial = (dlvm_pkg::ACC_W'(prod_ff[k-1])
                      + (dlvm_pkg::ACC_W'(den_ff[k-1]) << J)) << (J + 2);
      assign fit   = rem_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= fit ? root_ff[k-1] + (dlvm_pkg::ROOT_W'(1) << J) : root_ff[k-1];
         end
      end

      if (k < dlvm_pkg::STEPS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= fit ? rem_ff[k-1] - trial : rem_ff[k-1];
               prod_ff[k] <= fit ? prod_ff[k-1]
                                   + (dlvm_pkg::PROD_W'(den_ff[k-1]) << (J + 1))
                                 : prod_ff[k-1];
               den_ff[k]  <= den_ff[k-1];
            end
         end
      end
   end

   assign root_o = root_ff[dlvm_pkg::STEPS];

endmodule

### sv/directional_light_view_matrix_unit.sv
`timescale 1ns / 1ps

// look-at view matrix for a directional light. each beat on req carries one
// light direction (x, y, z in signed q4.12); each beat on rsp carries the
// rotation rows side, up and back in signed q2.14 (1.0 = 16384) and the z
// entry of the translation column (minus the vector length, q5.12). when the
// direction has x = z = 0 (zero or parallel to world up) the degenerate flag
// is set and every other field is zero. the block is fully pipelined: a new
// direction is taken every cycle while rsp is not stalled, and its result is
// presented on rsp from the last of 23 register stages (input register,
// squares, sums, a 17-stage bit-per-stage root unit, sign, product and
// rounding stages). the whole pipe advances together; while a result waits
// on rsp every stage holds, bubbles included, and req is not ready.
module directional_light_view_matrix_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // dir_x, dir_y, dir_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // side_x, side_y, side_z, up_x, up_y, up_z, back_x, back_y, back_z,
   // shift_z, zero pad
   output logic [167:0] rsp_tdata,
   output logic [0:0]   rsp_tuser    // degenerate
);

   localparam int ROOT_AT = 3 + dlvm_pkg::STEPS;   // stage where root results appear
   localparam int LAST    = ROOT_AT + 3;           // output register stage

   logic                    en;
   logic                    valid_ff [0:LAST];
   dlvm_pkg::tag_type       tag_ff   [0:LAST];
   dlvm_pkg::tag_type       tag_in;

   // stage 0: input register
   logic signed [15:0] dx_ff, dy_ff, dz_ff;
   // stage 1: squares
   logic signed [31:0] px, py, pz;
   logic [dlvm_pkg::SQ_W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   // stage 2: sums
   logic [dlvm_pkg::SQ_W-1:0]  sqx2_ff, sqy2_ff, sqz2_ff;
   logic [dlvm_pkg::SUM_W-1:0] q2_ff, s2_ff;
   logic [dlvm_pkg::SUM_W-1:0] q2_in, s2_in;

   // root results
   logic [dlvm_pkg::ROOT_W-1:0] m_side_x, m_side_z, m_back_x, m_back_y, m_back_z;
   logic [dlvm_pkg::ROOT_W-1:0] m_up_y, m_len;
   logic [dlvm_pkg::NUM_W-1:0]  len_num;

   // stage s1: signed rows
   logic signed [15:0] sx1_ff, sz1_ff, bx1_ff, by1_ff, bz1_ff, uy1_ff;
   logic [dlvm_pkg::ROOT_W-1:0] len1_ff;
   // stage s2: products
   logic signed [31:0] pux2_ff, puz2_ff;
   logic signed [15:0] sx2_ff, sz2_ff, bx2_ff, by2_ff, bz2_ff, uy2_ff;
   logic [dlvm_pkg::ROOT_W-1:0] len2_ff;
   // output register
   logic signed [15:0] sx_ff, sz_ff, ux_ff, uy_ff, uz_ff, bx_ff, by_ff, bz_ff;
   logic [dlvm_pkg::SHIFT_W-1:0] shz_ff;
   logic                         degen_ff;

   function automatic logic signed [15:0] apply_sign(
      input logic neg, input logic [dlvm_pkg::ROOT_W-1:0] mag);
      logic signed [15:0] v;
      v = signed'(mag[15:0]);
      return neg ? -v : v;
   endfunction

   // q14 product rounded half away from zero
   function automatic logic signed [15:0] round_q14(input logic signed [31:0] p);
      logic [31:0] m;
      logic [31:0] r;
      m = p[31] ? 32'(-p) : 32'(p);
      r = (m + 32'(1 << (dlvm_pkg::FRAC_Q - 1))) >> dlvm_pkg::FRAC_Q;
      return p[31] ? -signed'(r[15:0]) : signed'(r[15:0]);
   endfunction

   // whole pipe moves unless the output holds an untaken result
   assign en         = !valid_ff[LAST] || rsp_tready;
   assign req_tready = en;

   // side band: degenerate flag and component signs
   always_comb begin
      tag_in.degen = (req_tdata[15:0] == '0) && (req_tdata[47:32] == '0);
      tag_in.neg_x = req_tdata[15];
      tag_in.neg_y = req_tdata[31];
      tag_in.neg_z = req_tdata[47];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i <= LAST; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i <= LAST; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // stages 0 to 2: capture, squares, sums
   assign px = dx_ff * dx_ff;
   assign py = dy_ff * dy_ff;
   assign pz = dz_ff * dz_ff;

   assign q2_in = dlvm_pkg::SUM_W'(sqx_ff) + dlvm_pkg::SUM_W'(sqz_ff);
   assign s2_in = q2_in + dlvm_pkg::SUM_W'(sqy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= signed'(req_tdata[15:0]);
         dy_ff   <= signed'(req_tdata[31:16]);
         dz_ff   <= signed'(req_tdata[47:32]);
         sqx_ff  <= px[dlvm_pkg::SQ_W-1:0];
         sqy_ff  <= py[dlvm_pkg::SQ_W-1:0];
         sqz_ff  <= pz[dlvm_pkg::SQ_W-1:0];
         sqx2_ff <= sqx_ff;
         sqy2_ff <= sqy_ff;
         sqz2_ff <= sqz_ff;
         q2_ff   <= q2_in;
         s2_ff   <= s2_in;
      end
   end

   // rounded length: largest r with (2r-1)^2 <= 4 s2 - 1
   assign len_num = dlvm_pkg::NUM_W'({s2_ff, 2'b00}) - dlvm_pkg::NUM_W'(1);

   dlvm_root u_side_x (
      .clock (clock), .en (en), .den_i (q2_ff),
      .num_i ({1'b0, sqz2_ff, dlvm_pkg::NORM_SH'(0)}), .root_o (m_side_x)
   );
   dlvm_root u_side_z (
      .clock (clock), .en (en), .den_i (q2_ff),
      .num_i ({1'b0, sqx2_ff, dlvm_pkg::NORM_SH'(0)}), .root_o (m_side_z)
   );
   dlvm_root u_back_x (
      .clock (clock), .en (en), .den_i (s2_ff),
      .num_i ({1'b0, sqx2_ff, dlvm_pkg::NORM_SH'(0)}), .root_o (m_back_x)
   );
   dlvm_root u_back_y (
      .clock (clock), .en (en), .den_i (s2_ff),
      .num_i ({1'b0, sqy2_ff, dlvm_pkg::NORM_SH'(0)}), .root_o (m_back_y)
   );
   dlvm_root u_back_z (
      .clock (clock), .en (en), .den_i (s2_ff),
      .num_i ({1'b0, sqz2_ff, dlvm_pkg::NORM_SH'(0)}), .root_o (m_back_z)
   );
   dlvm_root u_up_y (
      .clock (clock), .en (en), .den_i (s2_ff),
      .num_i ({q2_ff, dlvm_pkg::NORM_SH'(0)}), .root_o (m_up_y)
   );
   dlvm_root u_len (
      .clock (clock), .en (en), .den_i (dlvm_pkg::DEN_W'(1)),
      .num_i (len_num), .root_o (m_len)
   );

   // s1: signs, s2: up row products, then rounding and zeroing
   always_ff @(posedge clock) begin
      if (en) begin
         sx1_ff  <= apply_sign(!tag_ff[ROOT_AT].neg_z, m_side_x);
         sz1_ff  <= apply_sign(tag_ff[ROOT_AT].neg_x, m_side_z);
         bx1_ff  <= apply_sign(!tag_ff[ROOT_AT].neg_x, m_back_x);
         by1_ff  <= apply_sign(!tag_ff[ROOT_AT].neg_y, m_back_y);
         bz1_ff  <= apply_sign(!tag_ff[ROOT_AT].neg_z, m_back_z);
         uy1_ff  <= signed'(m_up_y[15:0]);
         len1_ff <= m_len;

         pux2_ff <= sz1_ff * by1_ff;
         puz2_ff <= sx1_ff * by1_ff;
         sx2_ff  <= sx1_ff;
         sz2_ff  <= sz1_ff;
         bx2_ff  <= bx1_ff;
         by2_ff  <= by1_ff;
         bz2_ff  <= bz1_ff;
         uy2_ff  <= uy1_ff;
         len2_ff <= len1_ff;

         degen_ff <= tag_ff[LAST-1].degen;
         if (tag_ff[LAST-1].degen) begin
            sx_ff  <= '0;
            sz_ff  <= '0;
            ux_ff  <= '0;
            uy_ff  <= '0;
            uz_ff  <= '0;
            bx_ff  <= '0;
            by_ff  <= '0;
            bz_ff  <= '0;
            shz_ff <= '0;
         end else begin
            sx_ff  <= sx2_ff;
            sz_ff  <= sz2_ff;
            ux_ff  <= round_q14(pux2_ff);
            uy_ff  <= uy2_ff;
            uz_ff  <= -round_q14(puz2_ff);
            bx_ff  <= bx2_ff;
            by_ff  <= by2_ff;
            bz_ff  <= bz2_ff;
            shz_ff <= dlvm_pkg::SHIFT_W'(0) - len2_ff;
         end
      end
   end

   assign rsp_tvalid  = valid_ff[LAST];
   assign rsp_tuser   = degen_ff;
   assign rsp_tdata   = {7'b0, shz_ff, bz_ff, by_ff, bx_ff, uz_ff, uy_ff, ux_ff,
                         sz_ff, 16'b0, sx_ff};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;   // dir_x, dir_y, dir_z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;        // side xyz, up xyz, back xyz, shift_z, pad
   logic [0:0]   rsp_tuser;        // degenerate

   typedef struct {
      logic signed [15:0] rot [9];
      logic signed [16:0] shift_z;
      logic               degenerate;
   } view_mat_type;

   // integer helpers for the exact rounded square-root ratios
   function automatic longint q14_ratio(longint num2, longint den2);
      longint lo, hi, mid, t, odd;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) >>> 1;
         if (mid * mid * den2 <= (num2 <<< 28)) lo = mid;
         else hi = mid - 1;
      end
      t = lo;
      odd = 2 * t + 1;
      if (t < 16384 && (num2 <<< 30) >= den2 * odd * odd) t++;
      return t;
   endfunction

   function automatic longint sgn_ratio(longint c, longint den2);
      longint m;
      m = q14_ratio(c * c, den2);
      return c < 0 ? -m : m;
   endfunction

   function automatic longint q14_mul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = p < 0 ? -p : p;
      m = (m + 8192) >>> 14;
      return p < 0 ? -m : m;
   endfunction

   function automatic view_mat_type predict_view(logic [47:0] d);
      view_mat_type vm;
      longint dx, dy, dz, q2, s2, lo, hi, mid, r[9];
      dx = $signed(d[15:0]);
      dy = $signed(d[31:16]);
      dz = $signed(d[47:32]);
      foreach (vm.rot[i]) vm.rot[i] = '0;
      vm.shift_z = '0;
      vm.degenerate = 1'b1;
      if (dx == 0 && dz == 0) return vm;
      q2 = dx * dx + dz * dz;
      s2 = q2 + dy * dy;
      r[0] = -sgn_ratio(dz, q2);
      r[1] = 0;
      r[2] = sgn_ratio(dx, q2);
      r[6] = -sgn_ratio(dx, s2);
      r[7] = -sgn_ratio(dy, s2);
      r[8] = -sgn_ratio(dz, s2);
      r[3] = q14_mul(r[2], r[7]);
      r[4] = q14_ratio(q2, s2);
      r[5] = -q14_mul(r[0], r[7]);
      // rounded length, half up
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
         mid = (lo + hi + 1) >>> 1;
         if (mid * mid <= s2) lo = mid;
         else hi = mid - 1;
      end
      if (s2 - lo * lo > lo) lo++;
      foreach (r[i]) vm.rot[i] = r[i][15:0];
      vm.shift_z = 17'(-lo);
      vm.degenerate = 1'b0;
      return vm;
   endfunction

   class view_scoreboard;
      view_mat_type pending[$];
      int           errors;
      int           n_checked;
      int           n_degen;

      function void note_dir(logic [47:0] d);
         pending = {pending, predict_view(d)};
      endfunction

      function void check_rsp(logic [167:0] data, logic deg);
         string names[9] = '{"side_x", "side_y", "side_z", "up_x", "up_y", "up_z",
                             "back_x", "back_y", "back_z"};
         view_mat_type vm;
         if (pending.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
         end
         vm = pending.pop_front();
         n_checked++;
         if (vm.degenerate) n_degen++;
         for (int i = 0; i < 9; i++)
            if (data[16*i +: 16] !== vm.rot[i]) begin
               $error("%s expected %0d actual %0d", names[i], vm.rot[i],
                      $signed(data[16*i +: 16]));
               errors++;
            end
         if (data[144 +: 17] !== vm.shift_z) begin
            $error("shift_z expected %0d actual %0d", vm.shift_z, $signed(data[144 +: 17]));
            errors++;
         end
         if (deg !== vm.degenerate) begin
            $error("degenerate expected %0d actual %0d", vm.degenerate, deg);
            errors++;
         end
      endfunction
   endclass

   view_scoreboard sb = new();
   bit quiet_phase = 1'b0;   // no idling near the end of the run

   directional_light_view_matrix_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // accepted beats are sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_dir(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_rsp(rsp_tdata, rsp_tuser[0]);
   end

   // receiver: random stall bursts, then always ready
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // one beat; valid stays high across back-to-back beats
   task automatic send_dir(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      int gap;
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 8)) - 4);
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] dirs[20][3];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, axis-aligned and degenerate directions
      dirs = '{'{16'h0000, 16'h0000, 16'h0000}, '{16'h0000, 16'h1000, 16'h0000},
               '{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'h7FFF, 16'h0000},
               '{16'h1000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h1000},
               '{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF},
               '{16'h8000, 16'h7FFF, 16'h8000}, '{16'h7FFF, 16'h8000, 16'h7FFF},
               '{16'h0001, 16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
               '{16'h0001, 16'h7FFF, 16'h0001}, '{16'h0000, 16'h0001, 16'hFFFF},
               '{16'h8000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h8000},
               '{16'h1000, 16'h1000, 16'h1000}, '{16'hF000, 16'h1000, 16'h0800},
               '{16'h5555, 16'hAAAA, 16'h5555}, '{16'hAAAA, 16'h5555, 16'hAAAA}};
      foreach (dirs[i]) send_dir(dirs[i][0], dirs[i][1], dirs[i][2]);

      // sender holds off until the pipe has drained
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);

      for (int n = 0; n < 1900; n++) begin
         if (n == 1700) quiet_phase = 1'b1;
         send_dir(rand_comp(), rand_comp(), rand_comp());
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("checked %0d view matrices, %0d of them degenerate, under random stalls",
               sb.n_checked, sb.n_degen);
      if (sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for results");
      $display("== FAIL ==");
      $finish;
   end

endmodule
